// ===== rtl/picsf_pkg.sv =====
// ----------------------------------------------------------------------------
// Point-in-cylinder segment filter: shared definitions
// Field widths, stream packing offsets, register indexes and the command
// struct that passes from the controller to the datapath.
// ----------------------------------------------------------------------------
package picsf_pkg;

    // Table size and coordinate width.
    localparam int MAX_SEGMENTS  = 8;
    localparam int COORD_WIDTH   = 24;

    // Fixed field widths.
    localparam int DIR_WIDTH     = 18;
    localparam int DIR_FRAC      = 16;
    localparam int LEN_WIDTH     = 23;
    localparam int RAD_WIDTH     = 32;
    localparam int IDX_WIDTH     = 3;
    localparam int NUM_SEG_WIDTH = 4;

    // Squared distances are compared with 32 extra fraction bits.
    localparam int DIST_SHIFT    = 32;

    localparam int SEG_IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int SEG_CNT_W = $clog2(MAX_SEGMENTS + 1);

    // Length of the drain wait after the last issue, until the hit flag is final.
    localparam int PIPE_DRAIN  = 6;
    localparam int DRAIN_CNT_W = $clog2(PIPE_DRAIN);

    // Request kinds carried in s_tuser.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_POINT = 1'b1;

    // Configuration port.
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = NUM_SEG_WIDTH;
    localparam logic [CFG_ADDR_W-1:0] CFG_REG_ENABLED      = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_REG_NUM_SEGMENTS = 1'b1;

    // Input tdata packing, lowest field first.
    localparam int OFS_SEG_INDEX = 0;
    localparam int OFS_X         = OFS_SEG_INDEX + IDX_WIDTH;
    localparam int OFS_Y         = OFS_X + COORD_WIDTH;
    localparam int OFS_Z         = OFS_Y + COORD_WIDTH;
    localparam int OFS_DIR_X     = OFS_Z + COORD_WIDTH;
    localparam int OFS_DIR_Y     = OFS_DIR_X + DIR_WIDTH;
    localparam int OFS_DIR_Z     = OFS_DIR_Y + DIR_WIDTH;
    localparam int OFS_LEN       = OFS_DIR_Z + DIR_WIDTH;
    localparam int OFS_RAD       = OFS_LEN + LEN_WIDTH;
    localparam int S_FIELDS_W    = OFS_RAD + RAD_WIDTH;
    localparam int S_TDATA_W     = ((S_FIELDS_W + 7) / 8) * 8;

    // Output tdata packing: point x, y, z.
    localparam int M_FIELDS_W    = 3 * COORD_WIDTH;
    localparam int M_TDATA_W     = ((M_FIELDS_W + 7) / 8) * 8;

    typedef struct packed {
        logic [RAD_WIDTH-1:0]   sq_rad;
        logic [LEN_WIDTH-1:0]   len;
        logic [DIR_WIDTH-1:0]   dir_z;
        logic [DIR_WIDTH-1:0]   dir_y;
        logic [DIR_WIDTH-1:0]   dir_x;
        logic [COORD_WIDTH-1:0] base_z;
        logic [COORD_WIDTH-1:0] base_y;
        logic [COORD_WIDTH-1:0] base_x;
    } seg_entry_t;

    typedef struct packed {
        logic                 start;
        logic                 load_seg;
        logic                 issue;
        logic [SEG_IDX_W-1:0] issue_idx;
        logic                 out_load;
    } dp_cmd_t;

endpackage

// ===== rtl/picsf_ctrl.sv =====
// ----------------------------------------------------------------------------
// Point-in-cylinder segment filter: controller
// Holds the configuration registers, sequences segment reads into the
// datapath pipeline and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module picsf_ctrl
    import picsf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  s_req_type,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output dp_cmd_t               cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    localparam logic [DRAIN_CNT_W-1:0] DRAIN_LAST = DRAIN_CNT_W'(PIPE_DRAIN - 1);

    logic [1:0]               state_reg, state_next;
    logic [SEG_CNT_W-1:0]     seg_cnt_reg, seg_cnt_next;
    logic [DRAIN_CNT_W-1:0]   drain_cnt_reg, drain_cnt_next;
    logic                     enabled_reg, enabled_next;
    logic [NUM_SEG_WIDTH-1:0] num_seg_reg, num_seg_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [SEG_CNT_W-1:0]     n_eff;
    logic                     s_accept;

    assign s_tready   = (state_reg == ST_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign m_tvalid   = m_tvalid_reg;

    // Counts above the table size test the whole table.
    always_comb begin
        if (int'(num_seg_reg) > MAX_SEGMENTS) begin
            n_eff = SEG_CNT_W'(MAX_SEGMENTS);
        end else begin
            n_eff = SEG_CNT_W'(num_seg_reg);
        end
    end

    always_comb begin
        state_next     = state_reg;
        seg_cnt_next   = seg_cnt_reg;
        drain_cnt_next = drain_cnt_reg;
        enabled_next   = enabled_reg;
        num_seg_next   = num_seg_reg;
        cmd            = '0;

        if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_REG_ENABLED:      enabled_next = cfg_wdata[0];
                CFG_REG_NUM_SEGMENTS: num_seg_next = cfg_wdata[NUM_SEG_WIDTH-1:0];
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_req_type == REQ_POINT) begin
                        cmd.start = 1'b1;
                        if (enabled_reg && (n_eff != '0)) begin
                            state_next   = ST_ISSUE;
                            seg_cnt_next = '0;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end else begin
                        cmd.load_seg = 1'b1;
                    end
                end
            end
            ST_ISSUE: begin
                cmd.issue     = 1'b1;
                cmd.issue_idx = seg_cnt_reg[SEG_IDX_W-1:0];
                if (seg_cnt_reg == (n_eff - SEG_CNT_W'(1))) begin
                    state_next     = ST_DRAIN;
                    drain_cnt_next = '0;
                end else begin
                    seg_cnt_next = seg_cnt_reg + SEG_CNT_W'(1);
                end
            end
            ST_DRAIN: begin
                if (drain_cnt_reg == DRAIN_LAST) begin
                    state_next = ST_DONE;
                end else begin
                    drain_cnt_next = drain_cnt_reg + DRAIN_CNT_W'(1);
                end
            end
            ST_DONE: begin
                // Wait until the output register is empty or being emptied.
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            seg_cnt_reg   <= '0;
            drain_cnt_reg <= '0;
            enabled_reg   <= 1'b1;
            num_seg_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            seg_cnt_reg   <= seg_cnt_next;
            drain_cnt_reg <= drain_cnt_next;
            enabled_reg   <= enabled_next;
            num_seg_reg   <= num_seg_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

endmodule

// ===== rtl/picsf_datapath.sv =====
// ----------------------------------------------------------------------------
// Point-in-cylinder segment filter: datapath
// Segment table, a six-stage containment test that takes one segment per
// cycle, the hit accumulator and the output payload register.
// ----------------------------------------------------------------------------
module picsf_datapath
    import picsf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dp_cmd_t              cmd,
    input  logic [IDX_WIDTH-1:0] in_seg_index,
    input  seg_entry_t           in_entry,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tuser
);

    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int PROD_W  = DIFF_W + DIR_WIDTH;
    localparam int T_W     = PROD_W + 2;
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int D2_W    = SQ_W + 2;
    localparam int TR_W    = LEN_WIDTH + DIR_FRAC;
    localparam int RANGE_W = (T_W > TR_W) ? T_W : TR_W;
    localparam int TLO_W   = (TR_W + 1) / 2;
    localparam int THI_W   = TR_W - TLO_W;
    localparam int TSQ_W   = 2 * TR_W;
    localparam int TH_W    = TSQ_W - DIST_SHIFT;
    localparam int RH_W    = ((RAD_WIDTH > TH_W) ? RAD_WIDTH : TH_W) + 1;
    localparam int CMP_W   = (D2_W > RH_W) ? D2_W : RH_W;

    seg_entry_t seg_mem [MAX_SEGMENTS];
    seg_entry_t rd_entry_reg;

    logic [COORD_WIDTH-1:0] pt_x_reg, pt_y_reg, pt_z_reg;
    logic [6:1]             v_reg;
    logic                   hit_reg;

    // Stage 2: differences to the base point.
    logic signed [DIFF_W-1:0]    dx_reg, dy_reg, dz_reg;
    logic signed [DIR_WIDTH-1:0] dir_x_s2_reg, dir_y_s2_reg, dir_z_s2_reg;
    logic [LEN_WIDTH-1:0]        len_s2_reg, len_s3_reg, len_s4_reg;
    logic [RAD_WIDTH-1:0]        rad_s2_reg, rad_s3_reg, rad_s4_reg;
    logic [RAD_WIDTH-1:0]        rad_s5_reg, rad_s6_reg;

    // Stage 3: projection terms and squares.
    logic signed [PROD_W-1:0] prod_x_reg, prod_y_reg, prod_z_reg;
    logic signed [SQ_W-1:0]   sq_x_reg, sq_y_reg, sq_z_reg;

    // Stage 4: projection and squared distance.
    logic signed [T_W-1:0] t_reg;
    logic [D2_W-1:0]       d2_s4_reg, d2_s5_reg, d2_s6_reg;

    // Stage 5: partial products of the squared projection.
    logic [2*THI_W-1:0]     tsq_hh_reg;
    logic [THI_W+TLO_W-1:0] tsq_hl_reg;
    logic [2*TLO_W-1:0]     tsq_ll_reg;
    logic                   range_s5_reg, range_s6_reg;

    // Stage 6: squared projection, split at the distance fraction point.
    logic [TH_W-1:0] tsq_hi_reg;
    logic            tsq_lo_nz_reg;

    logic [TR_W-1:0]  t_mag;
    logic [THI_W-1:0] t_hi;
    logic [TLO_W-1:0] t_lo;
    logic             range_ok;
    logic [TSQ_W-1:0] tsq;
    logic [CMP_W-1:0] rh_ext, d2_ext;
    logic             seg_hit;

    always_ff @(posedge aclk) begin
        if (cmd.load_seg && (int'(in_seg_index) < MAX_SEGMENTS)) begin
            seg_mem[SEG_IDX_W'(in_seg_index)] <= in_entry;
        end
        rd_entry_reg <= seg_mem[cmd.issue_idx];
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            pt_x_reg <= in_entry.base_x;
            pt_y_reg <= in_entry.base_y;
            pt_z_reg <= in_entry.base_z;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg   <= '0;
            hit_reg <= 1'b0;
        end else begin
            v_reg <= {v_reg[5:1], cmd.issue};
            if (cmd.start) begin
                hit_reg <= 1'b0;
            end else if (v_reg[6] && seg_hit) begin
                hit_reg <= 1'b1;
            end
        end
    end

    // Projection must lie in [0, length]; length is aligned to the Q.16 projection.
    assign range_ok = !t_reg[T_W-1] &&
        (RANGE_W'($unsigned(t_reg)) <= RANGE_W'({len_s4_reg, {DIR_FRAC{1'b0}}}));

    // Only an in-range projection matters, so the low bits are enough to square.
    assign t_mag = TR_W'($unsigned(t_reg));
    assign t_hi  = t_mag[TR_W-1:TLO_W];
    assign t_lo  = t_mag[TLO_W-1:0];

    assign tsq = (TSQ_W'(tsq_hh_reg) << (2 * TLO_W))
               + (TSQ_W'(tsq_hl_reg) << (TLO_W + 1))
               + TSQ_W'(tsq_ll_reg);

    // d2 << 32 < (r << 32) + tsq reduces to a compare against r plus the
    // upper part of tsq, with ties broken by the lower 32 bits being nonzero.
    assign rh_ext  = CMP_W'(RH_W'(rad_s6_reg) + RH_W'(tsq_hi_reg));
    assign d2_ext  = CMP_W'(d2_s6_reg);
    assign seg_hit = range_s6_reg &&
                     ((d2_ext < rh_ext) || ((d2_ext == rh_ext) && tsq_lo_nz_reg));

    always_ff @(posedge aclk) begin
        dx_reg       <= {pt_x_reg[COORD_WIDTH-1], pt_x_reg}
                      - {rd_entry_reg.base_x[COORD_WIDTH-1], rd_entry_reg.base_x};
        dy_reg       <= {pt_y_reg[COORD_WIDTH-1], pt_y_reg}
                      - {rd_entry_reg.base_y[COORD_WIDTH-1], rd_entry_reg.base_y};
        dz_reg       <= {pt_z_reg[COORD_WIDTH-1], pt_z_reg}
                      - {rd_entry_reg.base_z[COORD_WIDTH-1], rd_entry_reg.base_z};
        dir_x_s2_reg <= rd_entry_reg.dir_x;
        dir_y_s2_reg <= rd_entry_reg.dir_y;
        dir_z_s2_reg <= rd_entry_reg.dir_z;
        len_s2_reg   <= rd_entry_reg.len;
        rad_s2_reg   <= rd_entry_reg.sq_rad;

        prod_x_reg <= dx_reg * dir_x_s2_reg;
        prod_y_reg <= dy_reg * dir_y_s2_reg;
        prod_z_reg <= dz_reg * dir_z_s2_reg;
        sq_x_reg   <= dx_reg * dx_reg;
        sq_y_reg   <= dy_reg * dy_reg;
        sq_z_reg   <= dz_reg * dz_reg;
        len_s3_reg <= len_s2_reg;
        rad_s3_reg <= rad_s2_reg;

        t_reg      <= T_W'(prod_x_reg) + T_W'(prod_y_reg) + T_W'(prod_z_reg);
        d2_s4_reg  <= D2_W'($unsigned(sq_x_reg)) + D2_W'($unsigned(sq_y_reg))
                    + D2_W'($unsigned(sq_z_reg));
        len_s4_reg <= len_s3_reg;
        rad_s4_reg <= rad_s3_reg;

        tsq_hh_reg   <= t_hi * t_hi;
        tsq_hl_reg   <= t_hi * t_lo;
        tsq_ll_reg   <= t_lo * t_lo;
        range_s5_reg <= range_ok;
        d2_s5_reg    <= d2_s4_reg;
        rad_s5_reg   <= rad_s4_reg;

        tsq_hi_reg    <= tsq[TSQ_W-1:DIST_SHIFT];
        tsq_lo_nz_reg <= |tsq[DIST_SHIFT-1:0];
        range_s6_reg  <= range_s5_reg;
        d2_s6_reg     <= d2_s5_reg;
        rad_s6_reg    <= rad_s5_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata <= M_TDATA_W'({pt_z_reg, pt_y_reg, pt_x_reg});
            m_tuser <= hit_reg;
        end
    end

endmodule

// ===== rtl/point_in_cylinder_segment_filter_unit.sv =====
// ----------------------------------------------------------------------------
// Point-in-cylinder segment filter
// Flags 3D points that fall inside any loaded finite cylinder segment.
// ----------------------------------------------------------------------------
// Usage:
// The s_ channel carries two kinds of transfer, selected by s_tuser. A load
// transfer writes one segment table entry and produces no output; the block
// stays ready for the next transfer. A point transfer produces one m_ transfer
// with the point and the drop flag in m_tuser. Software loads every segment
// below num_segments before it sends points, and writes the configuration
// only while idle. Each point walks the first N = min(num_segments, 8) table
// entries through a six-stage test pipeline, one entry read per cycle; the
// result goes to the output register once the pipeline has drained, and the
// next point is taken only after that. With the filter disabled or N zero no
// entries are read and the point goes straight to the output register.
// Reset enables the filter and sets num_segments to zero; table contents are
// undefined until loaded. One finished result can wait in the output register
// while the next point is accepted and processed; if m_tready stays low the
// block holds the following result and stops taking input until it drains.
// ----------------------------------------------------------------------------
module point_in_cylinder_segment_filter_unit
    import picsf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // seg_index, x, y, z, dir_x, dir_y, dir_z, seg_length, radius_squared
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // req_type
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // point_x, point_y, point_z
    output logic [M_TDATA_W-1:0]  m_tdata,
    // drop
    output logic                  m_tuser,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    dp_cmd_t              cmd;
    seg_entry_t           in_entry;
    logic [IDX_WIDTH-1:0] in_seg_index;

    assign in_seg_index    = s_tdata[OFS_SEG_INDEX +: IDX_WIDTH];
    assign in_entry.base_x = s_tdata[OFS_X +: COORD_WIDTH];
    assign in_entry.base_y = s_tdata[OFS_Y +: COORD_WIDTH];
    assign in_entry.base_z = s_tdata[OFS_Z +: COORD_WIDTH];
    assign in_entry.dir_x  = s_tdata[OFS_DIR_X +: DIR_WIDTH];
    assign in_entry.dir_y  = s_tdata[OFS_DIR_Y +: DIR_WIDTH];
    assign in_entry.dir_z  = s_tdata[OFS_DIR_Z +: DIR_WIDTH];
    assign in_entry.len    = s_tdata[OFS_LEN +: LEN_WIDTH];
    assign in_entry.sq_rad = s_tdata[OFS_RAD +: RAD_WIDTH];

    picsf_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_req_type (s_tuser),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .cmd        (cmd)
    );

    picsf_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .in_seg_index (in_seg_index),
        .in_entry     (in_entry),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser)
    );

endmodule
